// File: src/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg: shared types and constants for the touch contact tracker
// Item and result layouts, command codes, event kinds and sizing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int COORD_W     = 12;
  localparam int MAX_RESULTS = 8;
  localparam int CMDQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH  = 2;

  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_UP   = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [3:0]         track_id;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [15:0]        contact_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [3:0]         event_id;
    logic [COORD_W-1:0] event_x;
    logic [COORD_W-1:0] event_y;
    logic [15:0]        event_size;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic {
    CMD_POINT     = 1'b0,
    CMD_FRAME_END = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [3:0]         id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [15:0]        size;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POINT,
    BK_SCAN
  } back_state_t;

endpackage

`default_nettype wire

// File: src/tct_fifo.sv
// ----------------------------------------------------------------------------
// tct_fifo: small synchronous queue
// Register-based circular buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

endmodule

`default_nettype wire

// File: src/tct_front.sv
// ----------------------------------------------------------------------------
// tct_front: request intake and classification
// Registers one request, decodes it into a point or frame-end command and
// hands it to the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tct_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire tct_pkg::in_item_t in_item,
  output logic                   cmd_push,
  output tct_pkg::cmd_t          cmd_data,
  input  wire logic              cmd_full
);

  import tct_pkg::*;

  logic vld_r, vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take;

  assign in_full  = vld_r && cmd_full;
  assign take     = in_push && !in_full;
  assign cmd_push = vld_r;
  assign cmd_data = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    if (vld_r && !cmd_full) vld_nxt = 1'b0;
    if (take) vld_nxt = 1'b1;
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    cmd_nxt.id   = in_item.track_id;
    cmd_nxt.x    = in_item.pos_x;
    cmd_nxt.y    = in_item.pos_y;
    cmd_nxt.size = in_item.contact_size;
    unique case (in_item.operation)
      1'b1:    cmd_nxt.kind = CMD_FRAME_END;
      default: cmd_nxt.kind = CMD_POINT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

// File: src/tct_back.sv
// ----------------------------------------------------------------------------
// tct_back: slot table and event generation
// Executes point and frame-end commands against the slot table and emits
// down, move and up events into the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tct_back #(
  parameter int SLOTS = tct_pkg::SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  input  wire tct_pkg::cmd_t  cmd_data,
  output logic                ev_push,
  output tct_pkg::out_item_t  ev_data,
  input  wire logic           ev_full
);

  import tct_pkg::*;

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  back_state_t state_r, state_nxt;

  logic [SLOTS-1:0]   valid_r, seen_r, rel_r;
  logic [3:0]         track_r [SLOTS];
  logic [COORD_W-1:0] x_r     [SLOTS];
  logic [COORD_W-1:0] y_r     [SLOTS];
  cmd_t               cur_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [SLOTS-1:0] match_vec, rel_after;
  logic             hit, any_free, any_rel, take, moved, need_ev;
  logic [IW-1:0]    hit_idx, free_idx, up_idx, tgt_idx;
  logic             scan_done, point_fire, scan_fire;

  // priority encoders: lowest matching, free and releasable slot
  always_comb begin
    hit      = 1'b0;
    any_free = 1'b0;
    any_rel  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    up_idx   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      match_vec[s] = valid_r[s] && (track_r[s] == cur_r.id);
      if (match_vec[s] && !hit) begin
        hit     = 1'b1;
        hit_idx = IW'(s);
      end
      if (!valid_r[s] && !any_free) begin
        any_free = 1'b1;
        free_idx = IW'(s);
      end
      if (rel_r[s] && !any_rel) begin
        any_rel = 1'b1;
        up_idx  = IW'(s);
      end
    end
  end

  always_comb begin
    rel_after = rel_r;
    rel_after[up_idx] = 1'b0;
  end

  assign tgt_idx   = hit ? hit_idx : free_idx;
  assign take      = hit || any_free;
  assign moved     = (x_r[tgt_idx] != cur_r.x) || (y_r[tgt_idx] != cur_r.y);
  assign need_ev   = take && (!hit || moved);
  assign scan_done = !any_rel || (cnt_r == CNT_W'(MAX_RESULTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = (cmd_data.kind == CMD_FRAME_END) ? BK_SCAN : BK_POINT;
        end
      end
      BK_POINT: begin
        if (!need_ev || !ev_full) state_nxt = BK_IDLE;
      end
      BK_SCAN: begin
        if (scan_done) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop    = 1'b0;
    ev_push    = 1'b0;
    point_fire = 1'b0;
    scan_fire  = 1'b0;
    ev_data    = '0;
    unique case (state_r)
      BK_IDLE: begin
        cmd_pop = !cmd_empty;
      end
      BK_POINT: begin
        point_fire          = !need_ev || !ev_full;
        ev_push             = need_ev && !ev_full;
        ev_data.event_kind  = hit ? KIND_MOVE : KIND_DOWN;
        ev_data.event_id    = cur_r.id;
        ev_data.event_x     = cur_r.x;
        ev_data.event_y     = cur_r.y;
        ev_data.event_size  = cur_r.size;
        ev_data.last_of_run = 1'b1;
      end
      BK_SCAN: begin
        scan_fire           = !scan_done && !ev_full;
        ev_push             = scan_fire;
        ev_data.event_kind  = KIND_UP;
        ev_data.event_id    = track_r[up_idx];
        ev_data.event_x     = x_r[up_idx];
        ev_data.event_y     = y_r[up_idx];
        ev_data.event_size  = '0;
        // final up: nothing left to release or the per-frame cap is reached
        ev_data.last_of_run = (rel_after == '0) ||
                              (cnt_r == CNT_W'(MAX_RESULTS - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= '0;
      seen_r  <= '0;
      rel_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cmd_pop) begin
        rel_r <= valid_r & ~seen_r;
        cnt_r <= '0;
      end
      if (point_fire && take) begin
        valid_r[tgt_idx] <= 1'b1;
        seen_r[tgt_idx]  <= 1'b1;
      end
      if (scan_fire) begin
        valid_r[up_idx] <= 1'b0;
        rel_r           <= rel_after;
        cnt_r           <= cnt_r + CNT_W'(1);
      end
      if (state_r == BK_SCAN && scan_done) seen_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur_r <= cmd_data;
    if (point_fire && take) begin
      track_r[tgt_idx] <= cur_r.id;
      x_r[tgt_idx]     <= cur_r.x;
      y_r[tgt_idx]     <= cur_r.y;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push |-> !ev_full)
    else $error("event pushed into full result queue");

  a_unique_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_POINT) |-> $onehot0(match_vec))
    else $error("track id held by more than one valid slot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RESULTS))
    else $error("up count beyond per-frame cap");

  a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN && scan_done) |=> (seen_r == '0))
    else $error("seen marks not cleared at frame end");

endmodule

`default_nettype wire

// File: src/touch_contact_tracker_core.sv
// ----------------------------------------------------------------------------
// touch_contact_tracker_core: multitouch down/move/up event tracker
// Turns contact points and frame-end markers into touch events.
//
//   channel   ports                          direction  accepted when
//   input     in_push in_full in_item        in         in_push && !in_full
//   result    out_pop out_empty out_item     out        out_pop && !out_empty
//
// A point passes the intake register, the command queue and one slot-table
// lookup in the back end before its event enters the result queue.
// A frame end starts a release scan that emits one up event per cycle while
// the result queue is not full; at most 8 ups per frame end.
// Reset is synchronous; all slots come up free with no clearing sequence.
// A full result queue stalls the back end; the front keeps taking requests
// until the command queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module touch_contact_tracker_core #(
  parameter int SLOTS = tct_pkg::SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire tct_pkg::in_item_t  in_item,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output tct_pkg::out_item_t      out_item
);

  import tct_pkg::*;

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_in, cmd_out;
  logic      ev_push, ev_full;
  out_item_t ev_data;

  tct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  tct_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  tct_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_out),
    .ev_push   (ev_push),
    .ev_data   (ev_data),
    .ev_full   (ev_full)
  );

  tct_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .din   (ev_data),
    .full  (ev_full),
    .pop   (out_pop),
    .dout  (out_item),
    .empty (out_empty)
  );

endmodule

`default_nettype wire
